// ===== design/xalu_pkg.sv =====
// ----------------------------------------------------------------------------
// xalu_pkg: shared types and helpers for the integer ALU
// Action codes, flag bit positions, iterative unit request/response types,
// and width helpers used by the sequencer and the shared iterative unit.
// ----------------------------------------------------------------------------
package xalu_pkg;

    localparam int XLEN           = 64;
    localparam int DATA_WIDTH_DEF = 64;
    localparam int CNT_W          = 7;

    localparam int F_CF = 0;
    localparam int F_PF = 1;
    localparam int F_AF = 2;
    localparam int F_ZF = 3;
    localparam int F_SF = 4;
    localparam int F_OF = 5;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBB   = 5'd3,
        OP_AND   = 5'd4,
        OP_OR    = 5'd5,
        OP_XOR   = 5'd6,
        OP_CMP   = 5'd7,
        OP_TEST  = 5'd8,
        OP_INC   = 5'd9,
        OP_DEC   = 5'd10,
        OP_NEG   = 5'd11,
        OP_NOT   = 5'd12,
        OP_SHL   = 5'd13,
        OP_SHR   = 5'd14,
        OP_SAR   = 5'd15,
        OP_ROL   = 5'd16,
        OP_ROR   = 5'd17,
        OP_MUL   = 5'd18,
        OP_IMULW = 5'd19,
        OP_IMULT = 5'd20,
        OP_DIV   = 5'd21,
        OP_IDIV  = 5'd22,
        OP_COND  = 5'd23
    } t_action;

    typedef enum logic [1:0] {
        M_MUL = 2'd0,
        M_DIV = 2'd1,
        M_ROL = 2'd2,
        M_ROR = 2'd3
    } t_mode;

    typedef struct packed {
        logic             start;
        t_mode            mode;
        logic [XLEN-1:0]  x;
        logic [XLEN-1:0]  y;
        logic [XLEN-1:0]  h;
        logic [CNT_W-1:0] steps;
        logic [CNT_W-1:0] width;
    } t_iter_req;

    typedef struct packed {
        logic            done;
        logic [XLEN-1:0] hi;
        logic [XLEN-1:0] lo;
    } t_iter_rsp;

    function automatic logic [XLEN-1:0] f_mask(input logic [CNT_W-1:0] w);
        logic [XLEN-1:0] m;
        if (w >= CNT_W'(XLEN)) begin
            m = '1;
        end else begin
            m = (XLEN'(1) << w) - XLEN'(1);
        end
        return m;
    endfunction

    function automatic logic f_top(input logic [XLEN-1:0] v, input logic [CNT_W-1:0] w);
        logic [5:0] idx;
        idx = w[5:0] - 6'd1;
        return v[idx];
    endfunction

    function automatic logic [XLEN-1:0] f_sx(input logic [XLEN-1:0] v,
                                             input logic [CNT_W-1:0] w);
        logic [XLEN-1:0] m;
        m = f_mask(w);
        return (v & m) | (f_top(v, w) ? ~m : '0);
    endfunction

endpackage

// ===== design/xalu_iter.sv =====
// ----------------------------------------------------------------------------
// xalu_iter: shared iterative unit
// One step per cycle: shift-add multiply, restoring divide, or a single-bit
// rotate. Runs the requested number of steps and pulses done.
// ----------------------------------------------------------------------------
module xalu_iter
    import xalu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_iter_req i_req,
    output t_iter_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    t_mode            r_mode;
    logic [CNT_W-1:0] r_width;
    logic [CNT_W-1:0] r_cnt;
    logic [XLEN-1:0]  r_x;
    logic [XLEN-1:0]  r_hi;
    logic [XLEN-1:0]  r_lo;
    logic [XLEN-1:0]  n_hi;
    logic [XLEN-1:0]  n_lo;

    logic [XLEN:0]    w_sum;
    logic [XLEN:0]    w_rs;
    logic [XLEN:0]    w_diff;
    logic             w_ge;
    logic [XLEN-1:0]  w_m;
    logic [XLEN-1:0]  w_hib;
    logic             w_top;

    assign w_sum  = {1'b0, r_hi} + {1'b0, (r_lo[0] ? r_x : '0)};
    assign w_rs   = {r_hi, r_lo[XLEN-1]};
    assign w_diff = w_rs - {1'b0, r_x};
    assign w_ge   = (w_rs >= {1'b0, r_x});
    assign w_m    = f_mask(r_width);
    assign w_hib  = w_m ^ (w_m >> 1);
    assign w_top  = f_top(r_lo, r_width);

    always_comb begin
        n_hi = r_hi;
        n_lo = r_lo;
        case (r_mode)
            M_MUL: begin
                n_hi = w_sum[XLEN:1];
                n_lo = {w_sum[0], r_lo[XLEN-1:1]};
            end
            M_DIV: begin
                n_hi = w_ge ? w_diff[XLEN-1:0] : w_rs[XLEN-1:0];
                n_lo = {r_lo[XLEN-2:0], w_ge};
            end
            M_ROL: begin
                n_lo = ({r_lo[XLEN-2:0], 1'b0} | {{(XLEN-1){1'b0}}, w_top}) & w_m;
            end
            M_ROR: begin
                n_lo = ({1'b0, r_lo[XLEN-1:1]} | (r_lo[0] ? w_hib : '0)) & w_m;
            end
            default: begin
                n_lo = r_lo;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_mode <= M_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_mode  <= i_req.mode;
                r_cnt   <= i_req.steps;
                r_width <= i_req.width;
                r_x     <= i_req.x;
                r_hi    <= i_req.h;
                r_lo    <= i_req.y;
            end else if (r_busy) begin
                r_hi  <= n_hi;
                r_lo  <= n_lo;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.hi   = r_hi;
    assign o_rsp.lo   = r_lo;

endmodule

// ===== design/x86_integer_alu_with_flags.sv =====
// ----------------------------------------------------------------------------
// x86_integer_alu_with_flags: integer ALU with arithmetic flags
// Usage: one operation beat enters on i_valid/o_ready; one result beat leaves
// on o_valid/i_ready. o_ready is high only while the sequencer is idle.
// Path from accept to result valid:
//   add/sub/logic/shift/not/cond: computed in S_EXEC, then S_FIN
//   rol/ror: masked count steps (one bit per step in the shared unit)
//   mul/imul: 64 shift-add steps in the shared unit
//   div/idiv: operand width steps (one quotient bit per step);
//             no steps on a zero divisor or a high half too large,
//             idiv quotient overflow is found after the steps
// One item is in flight at a time; the next is accepted once the result
// has moved into the output register. A stalled receiver holds the result
// in the output register and the next result waits in the sequencer.
// The six flags persist between operations and update when a result moves
// to the output register. Reset clears the flags and empties the block.
// ----------------------------------------------------------------------------
module x86_integer_alu_with_flags
    import xalu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_action,
    input  logic [1:0]  i_size_code,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    input  logic [63:0] i_operand_high,
    input  logic [3:0]  i_cond_code,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result_low,
    output logic [63:0] o_result_high,
    output logic        o_writes_result,
    output logic [5:0]  o_flags_out,
    output logic        o_fault,
    output logic        o_cond_true
);

    localparam logic [CNT_W-1:0] DW = CNT_W'(DATA_WIDTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_ITER = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    function automatic logic [5:0] f_zsp(input logic [5:0] fl, input logic [63:0] r,
                                         input logic [CNT_W-1:0] w);
        logic [5:0] t;
        t       = fl;
        t[F_ZF] = (r == 64'd0);
        t[F_SF] = f_top(r, w);
        t[F_PF] = ~^r[7:0];
        return t;
    endfunction

    function automatic logic f_cond(input logic [5:0] fl, input logic [3:0] cc);
        logic v;
        case (cc[3:1])
            3'd0:    v = fl[F_OF];
            3'd1:    v = fl[F_CF];
            3'd2:    v = fl[F_ZF];
            3'd3:    v = fl[F_CF] | fl[F_ZF];
            3'd4:    v = fl[F_SF];
            3'd5:    v = fl[F_PF];
            3'd6:    v = fl[F_SF] ^ fl[F_OF];
            default: v = fl[F_ZF] | (fl[F_SF] ^ fl[F_OF]);
        endcase
        return cc[0] ? ~v : v;
    endfunction

    t_state      r_state;
    t_action     r_act;
    logic [1:0]  r_sz;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_h;
    logic [3:0]  r_cc;
    logic [5:0]  r_flags;
    logic        r_mneg;
    logic        r_nneg;
    logic        r_dneg;

    logic [63:0] r_rl;
    logic [63:0] r_rh;
    logic        r_wr;
    logic [5:0]  r_fl;
    logic        r_flt;
    logic        r_ct;

    logic        r_ovalid;
    logic [63:0] r_orl;
    logic [63:0] r_orh;
    logic        r_owr;
    logic [5:0]  r_ofl;
    logic        r_oflt;
    logic        r_oct;

    t_iter_req   w_req;
    t_iter_rsp   w_rsp;
    logic        w_load;
    logic        w_accept;

    logic [CNT_W-1:0] w_wfull;
    logic [CNT_W-1:0] w_w;
    logic [63:0] w_m;
    logic [63:0] w_a;
    logic [63:0] w_b;
    logic [63:0] w_hm;
    logic        w_cf;

    logic [63:0] as_x;
    logic [63:0] as_y;
    logic        as_c;
    logic        as_sub;
    logic [64:0] as_res;
    logic [63:0] as_r;
    logic [63:0] as_afx;
    logic        as_cf;
    logic        as_of;

    logic [5:0]  w_cnt;
    logic [5:0]  w_cm1;
    logic [5:0]  w_shl_idx;
    logic [63:0] w_shl;
    logic        w_shl_cf;
    logic [63:0] w_shr;
    logic [63:0] w_sxa;
    logic [63:0] w_sxb;
    logic [63:0] w_sar;
    logic [63:0] w_ma;
    logic [63:0] w_mb;
    logic [63:0] w_hsx;
    logic [127:0] w_num;
    logic [127:0] w_nmag;
    logic [63:0] w_nh;
    logic [63:0] w_nl;
    logic [63:0] w_dm;
    logic [CNT_W-1:0] w_algn;
    logic [63:0] w_lr;

    logic        e_go;
    logic [63:0] e_rl;
    logic        e_wr;
    logic [5:0]  e_fl;
    logic        e_flt;
    logic        e_ct;

    logic [127:0] w_ps;
    logic [63:0] w_plo;
    logic [63:0] w_phi;
    logic        w_ovf;
    logic        w_qneg;
    logic [63:0] w_lim;
    logic [63:0] p_rl;
    logic [63:0] p_rh;
    logic        p_wr;
    logic [5:0]  p_fl;
    logic        p_flt;

    assign w_wfull = CNT_W'(8) << r_sz;
    assign w_w     = (w_wfull > DW) ? DW : w_wfull;
    assign w_m     = f_mask(w_w);
    assign w_a     = r_a & w_m;
    assign w_b     = r_b & w_m;
    assign w_hm    = r_h & w_m;
    assign w_cf    = r_flags[F_CF];

    always_comb begin
        as_x   = w_a;
        as_y   = w_b;
        as_c   = 1'b0;
        as_sub = 1'b0;
        case (r_act)
            OP_ADC: as_c = w_cf;
            OP_SUB, OP_CMP: as_sub = 1'b1;
            OP_SBB: begin
                as_sub = 1'b1;
                as_c   = w_cf;
            end
            OP_INC: as_y = 64'd1;
            OP_DEC: begin
                as_sub = 1'b1;
                as_y   = 64'd1;
            end
            OP_NEG: begin
                as_sub = 1'b1;
                as_x   = 64'd0;
                as_y   = w_a;
            end
            default: as_c = 1'b0;
        endcase
    end

    assign as_res = as_sub ? ({1'b0, as_x} - {1'b0, as_y} - {64'd0, as_c})
                           : ({1'b0, as_x} + {1'b0, as_y} + {64'd0, as_c});
    assign as_r   = as_res[63:0] & w_m;
    assign as_afx = as_x ^ as_y ^ as_r;
    assign as_cf  = as_sub ? as_res[64] : as_res[w_w];
    assign as_of  = as_sub ? f_top((as_x ^ as_y) & (as_x ^ as_r), w_w)
                           : f_top((as_x ^ as_r) & (as_y ^ as_r), w_w);

    assign w_cnt     = r_b[5:0] & ((w_w > CNT_W'(32)) ? 6'd63 : 6'd31);
    assign w_cm1     = w_cnt - 6'd1;
    assign w_shl_idx = 6'(w_w - {1'b0, w_cnt});
    assign w_shl     = (w_a << w_cnt) & w_m;
    assign w_shl_cf  = ({1'b0, w_cnt} <= w_w) ? w_a[w_shl_idx] : 1'b0;
    assign w_shr     = w_a >> w_cnt;
    assign w_sxa     = f_sx(w_a, w_w);
    assign w_sxb     = f_sx(w_b, w_w);
    assign w_sar     = 64'($signed(w_sxa) >>> w_cnt) & w_m;
    assign w_ma      = w_sxa[63] ? (64'd0 - w_sxa) : w_sxa;
    assign w_mb      = w_sxb[63] ? (64'd0 - w_sxb) : w_sxb;
    assign w_hsx     = f_sx(w_hm, w_w);
    assign w_num     = ({{64{w_hsx[63]}}, w_hsx} << w_w) | {64'd0, w_a};
    assign w_nmag    = w_hsx[63] ? (128'd0 - w_num) : w_num;
    assign w_nh      = 64'(w_nmag >> w_w);
    assign w_nl      = w_nmag[63:0] & w_m;
    assign w_dm      = w_mb;
    assign w_algn    = CNT_W'(64) - w_w;

    always_comb begin
        e_go        = 1'b0;
        e_rl        = 64'd0;
        e_wr        = 1'b0;
        e_fl        = r_flags;
        e_flt       = 1'b0;
        e_ct        = 1'b0;
        w_lr        = 64'd0;
        w_req.mode  = M_MUL;
        w_req.x     = 64'd0;
        w_req.y     = 64'd0;
        w_req.h     = 64'd0;
        w_req.steps = CNT_W'(64);
        w_req.width = w_w;
        case (r_act)
            OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_CMP, OP_INC, OP_DEC, OP_NEG: begin
                e_fl[F_CF] = as_cf;
                e_fl[F_OF] = as_of;
                e_fl[F_AF] = as_afx[4];
                e_fl       = f_zsp(e_fl, as_r, w_w);
                if (r_act == OP_INC || r_act == OP_DEC) begin
                    e_fl[F_CF] = w_cf;
                end
                if (r_act == OP_NEG) begin
                    e_fl[F_CF] = (w_a != 64'd0);
                end
                if (r_act != OP_CMP) begin
                    e_rl = as_r;
                    e_wr = 1'b1;
                end
            end
            OP_AND, OP_OR, OP_XOR, OP_TEST: begin
                case (r_act)
                    OP_OR:   w_lr = w_a | w_b;
                    OP_XOR:  w_lr = w_a ^ w_b;
                    default: w_lr = w_a & w_b;
                endcase
                e_fl[F_CF] = 1'b0;
                e_fl[F_OF] = 1'b0;
                e_fl[F_AF] = 1'b0;
                e_fl       = f_zsp(e_fl, w_lr, w_w);
                if (r_act != OP_TEST) begin
                    e_rl = w_lr;
                    e_wr = 1'b1;
                end
            end
            OP_NOT: begin
                e_rl = ~w_a & w_m;
                e_wr = 1'b1;
            end
            OP_SHL, OP_SHR, OP_SAR: begin
                if (w_cnt != 6'd0) begin
                    case (r_act)
                        OP_SHL: begin
                            e_rl       = w_shl;
                            e_fl[F_CF] = w_shl_cf;
                            e_fl[F_OF] = f_top(w_shl, w_w) ^ w_shl_cf;
                        end
                        OP_SHR: begin
                            e_rl       = w_shr;
                            e_fl[F_CF] = w_a[w_cm1];
                            e_fl[F_OF] = f_top(w_a, w_w);
                        end
                        default: begin
                            e_rl       = w_sar;
                            e_fl[F_CF] = w_sxa[w_cm1];
                            e_fl[F_OF] = 1'b0;
                        end
                    endcase
                    e_fl[F_AF] = 1'b0;
                    e_fl       = f_zsp(e_fl, e_rl, w_w);
                    e_wr       = 1'b1;
                end
            end
            OP_ROL, OP_ROR: begin
                if (w_cnt != 6'd0) begin
                    e_go        = 1'b1;
                    w_req.mode  = (r_act == OP_ROL) ? M_ROL : M_ROR;
                    w_req.y     = w_a;
                    w_req.steps = {1'b0, w_cnt};
                end
            end
            OP_MUL, OP_IMULW, OP_IMULT: begin
                e_go       = 1'b1;
                w_req.mode = M_MUL;
                w_req.x    = (r_act == OP_MUL) ? w_a : w_ma;
                w_req.y    = (r_act == OP_MUL) ? w_b : w_mb;
            end
            OP_DIV: begin
                if (w_hm >= w_b) begin
                    e_flt = 1'b1;
                end else begin
                    e_go        = 1'b1;
                    w_req.mode  = M_DIV;
                    w_req.x     = w_b;
                    w_req.h     = w_hm;
                    w_req.y     = w_a << w_algn;
                    w_req.steps = w_w;
                end
            end
            OP_IDIV: begin
                if (w_nh >= w_dm) begin
                    e_flt = 1'b1;
                end else begin
                    e_go        = 1'b1;
                    w_req.mode  = M_DIV;
                    w_req.x     = w_dm;
                    w_req.h     = w_nh;
                    w_req.y     = w_nl << w_algn;
                    w_req.steps = w_w;
                end
            end
            OP_COND: begin
                e_ct = f_cond(r_flags, r_cc);
            end
            default: begin
                e_wr = 1'b0;
            end
        endcase
        w_req.start = (r_state == S_EXEC) && e_go;
    end

    xalu_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_ps   = r_mneg ? (128'd0 - {w_rsp.hi, w_rsp.lo}) : {w_rsp.hi, w_rsp.lo};
    assign w_plo  = w_ps[63:0] & w_m;
    assign w_phi  = 64'(w_ps >> w_w) & w_m;
    assign w_ovf  = (r_act == OP_MUL) ? (w_phi != 64'd0)
                                      : (w_phi != (f_top(w_plo, w_w) ? w_m : 64'd0));
    assign w_qneg = r_nneg ^ r_dneg;
    assign w_lim  = (64'd1 << (w_w - CNT_W'(1))) - 64'd1 + {63'd0, w_qneg};

    always_comb begin
        p_rl  = 64'd0;
        p_rh  = 64'd0;
        p_wr  = 1'b1;
        p_fl  = r_flags;
        p_flt = 1'b0;
        case (r_act)
            OP_ROL: begin
                p_rl       = w_rsp.lo;
                p_fl[F_CF] = w_rsp.lo[0];
                p_fl[F_OF] = f_top(w_rsp.lo, w_w) ^ w_rsp.lo[0];
            end
            OP_ROR: begin
                p_rl       = w_rsp.lo;
                p_fl[F_CF] = f_top(w_rsp.lo, w_w);
                p_fl[F_OF] = f_top(w_rsp.lo, w_w) ^ f_top(w_rsp.lo, w_w - CNT_W'(1));
            end
            OP_DIV: begin
                p_rl = w_rsp.lo;
                p_rh = w_rsp.hi;
            end
            OP_IDIV: begin
                if (w_rsp.lo > w_lim) begin
                    p_flt = 1'b1;
                    p_wr  = 1'b0;
                end else begin
                    p_rl = (w_qneg ? (64'd0 - w_rsp.lo) : w_rsp.lo) & w_m;
                    p_rh = (r_nneg ? (64'd0 - w_rsp.hi) : w_rsp.hi) & w_m;
                end
            end
            default: begin
                p_fl[F_CF] = w_ovf;
                p_fl[F_OF] = w_ovf;
                p_fl[F_AF] = 1'b0;
                p_fl       = f_zsp(p_fl, w_plo, w_w);
                p_rl       = w_plo;
                p_rh       = (r_act == OP_IMULT) ? 64'd0 : w_phi;
            end
        endcase
    end

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_load   = (r_state == S_FIN) && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_flags  <= 6'd0;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= e_go ? S_ITER : S_FIN;
                end
                S_ITER: begin
                    if (w_rsp.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_load) begin
                r_ovalid <= 1'b1;
                r_flags  <= r_fl;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act <= t_action'(i_action);
            r_sz  <= i_size_code;
            r_a   <= i_operand_a;
            r_b   <= i_operand_b;
            r_h   <= i_operand_high;
            r_cc  <= i_cond_code;
        end
        if (r_state == S_EXEC) begin
            r_mneg <= (r_act != OP_MUL) && (w_sxa[63] ^ w_sxb[63]);
            r_nneg <= w_hsx[63];
            r_dneg <= w_sxb[63];
            r_rl   <= e_rl;
            r_rh   <= 64'd0;
            r_wr   <= e_wr;
            r_fl   <= e_fl;
            r_flt  <= e_flt;
            r_ct   <= e_ct;
        end else if (r_state == S_ITER && w_rsp.done) begin
            r_rl  <= p_rl;
            r_rh  <= p_rh;
            r_wr  <= p_wr;
            r_fl  <= p_fl;
            r_flt <= p_flt;
            r_ct  <= 1'b0;
        end
        if (w_load) begin
            r_orl  <= r_rl;
            r_orh  <= r_rh;
            r_owr  <= r_wr;
            r_ofl  <= r_fl;
            r_oflt <= r_flt;
            r_oct  <= r_ct;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_result_low    = r_orl;
    assign o_result_high   = r_orh;
    assign o_writes_result = r_owr;
    assign o_flags_out     = r_ofl;
    assign o_fault         = r_oflt;
    assign o_cond_true     = r_oct;

    a_fault_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_fault && o_writes_result))
        else $error("fault beat also writes result");

    a_cond_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cond_true) |-> !o_writes_result)
        else $error("condition beat writes result");

    a_done_in_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_ITER))
        else $error("shared unit finished outside iteration");

    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_load |=> $stable(r_flags))
        else $error("flags changed without a result load");

endmodule
